// ----- sv/itd_pkg.sv -----
// ----------------------------------------------------------------------------
// itd_pkg
// Shared types and constants for the integer-to-decimal-text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itd_pkg;

  // input word and digit chain sizes
  localparam int unsigned WordW     = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BitCntW   = $clog2(WordW);
  localparam int unsigned RemW      = $clog2(NumDigits + 1);

  // character codes
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  // per-cycle operation handed to every digit cell
  typedef struct packed {
    logic clear;   // load zero into the digit
    logic dabble;  // add-3 correction, then shift one bit in from below
    logic pass;    // take the whole digit of the lower neighbor
  } itd_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/itd_bcd_cell.sv -----
// ----------------------------------------------------------------------------
// itd_bcd_cell
// One BCD digit of the conversion chain: shift-and-add-3 step while
// converting, whole-digit shift toward the top while emitting.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_bcd_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  itd_pkg::itd_cell_ctrl_t          ctrl_i,
  input  wire                              carry_i,
  input  wire  [itd_pkg::DigitW-1:0]       digit_i,
  output logic                             carry_o,
  output logic [itd_pkg::DigitW-1:0]       digit_o
);

  logic [itd_pkg::DigitW-1:0] digit_q, digit_d;
  logic [itd_pkg::DigitW-1:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  always_comb begin
    if (digit_q >= itd_pkg::DigitW'(5)) begin
      adj = digit_q + itd_pkg::DigitW'(3);
    end else begin
      adj = digit_q;
    end
  end

  // next digit select
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[itd_pkg::DigitW-2:0], carry_i};
    end else if (ctrl_i.pass) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign carry_o = adj[itd_pkg::DigitW-1];
  assign digit_o = digit_q;

endmodule

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal text, one ASCII byte per
// result: optional '-', then digits most significant first, no leading zeros.
//
//   channel   direction  ports                         handshake
//   request   in         value_i                       start & !busy
//   result    out        char_code_o, last_o           valid_o strobe
//
// A request runs in three phases: the accept cycle (which also emits '-' for a
// negative value), 32 shift-and-add-3 steps through the ten-cell digit chain,
// then ten shift-out steps of the chain, leading zeros being dropped.
// busy is high from the accept until the last digit leaves the chain.
// Reset is asynchronous, active low, and returns the block to idle.
// The receiver cannot stall; each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  input  wire  signed [itd_pkg::WordW-1:0] value_i,
  output logic                            busy,
  output logic                            valid_o,
  output logic [7:0]                      char_code_o,
  output logic                            last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [itd_pkg::WordW-1:0]         mag_q, mag_d;
  logic [itd_pkg::BitCntW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [itd_pkg::RemW-1:0]          rem_q, rem_d;
  logic                              started_q, started_d;
  logic                              valid_q, valid_d;
  logic [7:0]                        char_q, char_d;
  logic                              last_q, last_d;

  logic                              accept;
  logic                              neg;
  logic [itd_pkg::WordW-1:0]         raw;
  itd_pkg::itd_cell_ctrl_t           cell_ctrl;
  logic [itd_pkg::DigitW-1:0]        digit [itd_pkg::NumDigits];
  logic                              carry [itd_pkg::NumDigits];
  logic [itd_pkg::DigitW-1:0]        top_digit;
  logic                              show;

  assign accept    = start && !busy;
  assign raw       = $unsigned(value_i);
  assign neg       = raw[itd_pkg::WordW-1];
  assign top_digit = digit[itd_pkg::NumDigits-1];
  assign show      = started_q || (top_digit != '0) || (rem_q == itd_pkg::RemW'(1));

  // digit chain: cell 0 takes the magnitude msb, each cell feeds the next
  for (genvar k = 0; k < itd_pkg::NumDigits; k++) begin : g_cell
    if (k == 0) begin : g_first
      itd_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .carry_i (mag_q[itd_pkg::WordW-1]),
        .digit_i ('0),
        .carry_o (carry[k]),
        .digit_o (digit[k])
      );
    end else begin : g_next
      itd_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .carry_i (carry[k-1]),
        .digit_i (digit[k-1]),
        .carry_o (carry[k]),
        .digit_o (digit[k])
      );
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    bit_cnt_d = bit_cnt_q;
    rem_d     = rem_q;
    started_d = started_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    cell_ctrl = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          // sign goes out right away, the chain starts from zero
          mag_d          = neg ? (~raw + itd_pkg::WordW'(1)) : raw;
          bit_cnt_d      = '0;
          started_d      = 1'b0;
          cell_ctrl.clear = 1'b1;
          valid_d        = neg;
          char_d         = itd_pkg::AsciiMinus;
          last_d         = 1'b0;
          state_d        = StConv;
        end
      end
      StConv: begin
        // one double-dabble step per cycle
        cell_ctrl.dabble = 1'b1;
        mag_d            = {mag_q[itd_pkg::WordW-2:0], 1'b0};
        bit_cnt_d        = bit_cnt_q + itd_pkg::BitCntW'(1);
        if (bit_cnt_q == itd_pkg::BitCntW'(itd_pkg::WordW - 1)) begin
          rem_d   = itd_pkg::RemW'(itd_pkg::NumDigits);
          state_d = StEmit;
        end
      end
      StEmit: begin
        // top digit leaves, chain shifts up, leading zeros dropped
        cell_ctrl.pass = 1'b1;
        valid_d        = show;
        char_d         = itd_pkg::AsciiZero + {4'b0000, top_digit};
        last_d         = (rem_q == itd_pkg::RemW'(1));
        started_d      = show;
        rem_d          = rem_q - itd_pkg::RemW'(1);
        if (rem_q == itd_pkg::RemW'(1)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy        = (state_q != StIdle);
  assign valid_o     = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a request");

  // a minus sign never ends a run
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (char_code_o == itd_pkg::AsciiMinus) |-> !last_o)
    else $error("minus sign flagged as last character");

  // more characters pending means the block is still working
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("run unfinished while block idle");
`endif

endmodule

`default_nettype wire
